// ----- src/bptc_pkg.sv -----
// Shared types and constants for the bipartite two-coloring check unit.
// Depends on nothing; the top level refers to it by scoped names.
`default_nettype none

package bptc_pkg;

    // Operation codes carried by the mode field of an input word.
    localparam logic [1:0] ModeAddEdge  = 2'd0;
    localparam logic [1:0] ModeEvaluate = 2'd1;
    localparam logic [1:0] ModeClear    = 2'd2;

    // Register map of the configuration port.
    localparam int          CfgAddrWidth    = 3;
    localparam logic        CfgIdxVertCount = 1'b0;
    localparam logic [6:0]  VertCountReset  = 7'd64;

    // Fixed widths of the word fields.
    localparam int ModeWidth   = 2;
    localparam int VertexWidth = 6;
    localparam int ResultWidth = 7;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ADD  = 6'b000010,
        S_SCAN = 6'b000100,
        S_CHK  = 6'b001000,
        S_POP  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

endpackage

`default_nettype wire

// ----- src/bipartite_two_coloring_check_unit.sv -----
// Top level of the bipartite two-coloring check: adjacency matrix memory,
// depth-first walk sequencer, color store and walk stack.
// Depends on bptc_pkg.
// Add edge reads the source row, then writes it back with the edge bit merged; clear and
// unused modes finish in idle. An evaluate word walks depth first, scanning the columns
// below vertex_count of each vertex it enters, one per cycle unless a set bit calls a
// color check, popping on each return; a stalled result output holds it in the done state.
// Throughput: one word at a time; the input is not ready until the word is done.
// Reset: matrix reads empty at once through per-row valid bits, vertex_count
// is 64, no result pending; no clearing pass is needed.
`default_nettype none

module bipartite_two_coloring_check_unit #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input words
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic [bptc_pkg::ModeWidth-1:0]        i_mode,
    input  wire logic [bptc_pkg::VertexWidth-1:0]      i_edge_source,
    input  wire logic [bptc_pkg::VertexWidth-1:0]      i_edge_target,
    // result words
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic                                       o_two_colorable,
    output logic [bptc_pkg::ResultWidth-1:0]           o_smaller_side_count,
    // configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [bptc_pkg::CfgAddrWidth-1:0]     paddr,
    input  wire logic [31:0]                           pwdata,
    output logic [31:0]                                prdata,
    output logic                                       pready
);

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int SW = VW + CW;
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_VERTICES);

    // Configuration register.
    logic [6:0] r_vcount;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[2] == bptc_pkg::CfgIdxVertCount);
    assign prdata = (paddr[2] == bptc_pkg::CfgIdxVertCount) ? {25'd0, r_vcount} : 32'd0;

    // Memories.
    logic [MAX_VERTICES-1:0] r_adj_mem   [MAX_VERTICES];
    logic                    r_color_mem [MAX_VERTICES];
    logic [SW-1:0]           r_stack_mem [MAX_VERTICES];

    logic [MAX_VERTICES-1:0] r_row_valid, n_row_valid;
    logic [MAX_VERTICES-1:0] r_adj_rd;
    logic                    r_color_rd;
    logic [SW-1:0]           r_stack_rd;

    // Walk state.
    bptc_pkg::t_state        r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_depth, n_depth;
    logic [VW-1:0]           r_top_v, n_top_v;
    logic [CW-1:0]           r_top_col, n_top_col;
    logic [CW-1:0]           r_red, n_red;
    logic [CW-1:0]           r_blue, n_blue;
    logic [MAX_VERTICES-1:0] r_colored, n_colored;
    logic                    r_ok, n_ok;
    logic [VW-1:0]           r_add_src, n_add_src;
    logic [VW-1:0]           r_add_dst, n_add_dst;

    // Result register.
    logic                               r_out_valid, n_out_valid;
    logic                               r_out_ok, n_out_ok;
    logic [bptc_pkg::ResultWidth-1:0]   r_out_cnt, n_out_cnt;

    // Memory controls.
    logic                    adj_re, adj_we;
    logic [VW-1:0]           adj_raddr, adj_waddr;
    logic [MAX_VERTICES-1:0] adj_wdata;
    logic                    col_re, col_we, col_wdata;
    logic [VW-1:0]           col_raddr, col_waddr;
    logic                    stk_re, stk_we;
    logic [VW-1:0]           stk_raddr, stk_waddr;
    logic [SW-1:0]           stk_wdata;

    // Helpers.
    logic          in_acc;
    logic [31:0]   src32, dst32, vc32;
    logic [CW-1:0] eff_count;
    logic [VW-1:0] col_idx;
    logic [CW-1:0] depth_m1, depth_m2, larger;

    assign o_ready = (r_state == bptc_pkg::S_IDLE);
    assign in_acc  = i_valid && o_ready;

    assign src32 = 32'(i_edge_source);
    assign dst32 = 32'(i_edge_target);
    assign vc32  = 32'(r_vcount);
    assign eff_count = (vc32 == 32'd0) ? CW'(1)
                     : ((vc32 > 32'(MAX_VERTICES)) ? MaxCnt : CW'(vc32));

    assign col_idx  = r_top_col[VW-1:0];
    assign depth_m1 = r_depth - CW'(1);
    assign depth_m2 = r_depth - CW'(2);
    assign larger   = (r_red >= r_blue) ? r_red : r_blue;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_depth     = r_depth;
        n_top_v     = r_top_v;
        n_top_col   = r_top_col;
        n_red       = r_red;
        n_blue      = r_blue;
        n_colored   = r_colored;
        n_ok        = r_ok;
        n_add_src   = r_add_src;
        n_add_dst   = r_add_dst;
        n_row_valid = r_row_valid;
        n_out_valid = r_out_valid && !i_ready;
        n_out_ok    = r_out_ok;
        n_out_cnt   = r_out_cnt;

        adj_re    = 1'b0;
        adj_raddr = r_top_v;
        adj_we    = 1'b0;
        adj_waddr = r_add_src;
        adj_wdata = r_adj_rd | (MAX_VERTICES'(1) << r_add_dst);
        col_re    = 1'b0;
        col_raddr = col_idx;
        col_we    = 1'b0;
        col_waddr = col_idx;
        col_wdata = r_depth[0];
        stk_re    = 1'b0;
        stk_raddr = depth_m2[VW-1:0];
        stk_we    = 1'b0;
        stk_waddr = depth_m1[VW-1:0];
        stk_wdata = {r_top_v, r_top_col + CW'(1)};

        case (r_state)
            bptc_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_mode)
                        bptc_pkg::ModeAddEdge: begin
                            // Read the source row first; the edge bit is merged next cycle.
                            if (src32 < 32'(MAX_VERTICES) && dst32 < 32'(MAX_VERTICES)) begin
                                n_add_src = src32[VW-1:0];
                                n_add_dst = dst32[VW-1:0];
                                adj_re    = 1'b1;
                                adj_raddr = src32[VW-1:0];
                                n_state   = bptc_pkg::S_ADD;
                            end
                        end
                        bptc_pkg::ModeClear: begin
                            n_row_valid = '0;
                        end
                        bptc_pkg::ModeEvaluate: begin
                            // Vertex 0 takes the first color and opens the walk.
                            n_count   = eff_count;
                            n_depth   = CW'(1);
                            n_top_v   = '0;
                            n_top_col = '0;
                            n_red     = CW'(1);
                            n_blue    = '0;
                            n_colored = MAX_VERTICES'(1);
                            n_ok      = 1'b1;
                            col_we    = 1'b1;
                            col_waddr = '0;
                            col_wdata = 1'b0;
                            adj_re    = 1'b1;
                            adj_raddr = '0;
                            n_state   = bptc_pkg::S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bptc_pkg::S_ADD: begin
                adj_we = 1'b1;
                n_row_valid[r_add_src] = 1'b1;
                n_state = bptc_pkg::S_IDLE;
            end
            bptc_pkg::S_SCAN: begin
                if (r_top_col >= r_count) begin
                    if (r_depth == CW'(1)) begin
                        n_depth = '0;
                        n_state = bptc_pkg::S_DONE;
                    end else begin
                        stk_re  = 1'b1;
                        n_state = bptc_pkg::S_POP;
                    end
                end else if (r_adj_rd[col_idx]) begin
                    col_re  = 1'b1;
                    n_state = bptc_pkg::S_CHK;
                end else begin
                    n_top_col = r_top_col + CW'(1);
                end
            end
            bptc_pkg::S_CHK: begin
                // The color of a stacked vertex follows from its depth: odd depth
                // holds the first color, stored as 0.
                if (!r_colored[col_idx]) begin
                    n_colored[col_idx] = 1'b1;
                    col_we = 1'b1;
                    if (r_depth[0]) begin
                        n_blue = r_blue + CW'(1);
                    end else begin
                        n_red = r_red + CW'(1);
                    end
                    if (r_depth != MaxCnt) begin
                        stk_we    = 1'b1;
                        n_top_v   = col_idx;
                        n_top_col = '0;
                        n_depth   = r_depth + CW'(1);
                        adj_re    = 1'b1;
                        adj_raddr = col_idx;
                    end else begin
                        n_top_col = r_top_col + CW'(1);
                    end
                    n_state = bptc_pkg::S_SCAN;
                end else if (r_color_rd == !r_depth[0]) begin
                    n_ok    = 1'b0;
                    n_depth = '0;
                    n_state = bptc_pkg::S_DONE;
                end else begin
                    n_top_col = r_top_col + CW'(1);
                    n_state   = bptc_pkg::S_SCAN;
                end
            end
            bptc_pkg::S_POP: begin
                n_top_v   = r_stack_rd[SW-1:CW];
                n_top_col = r_stack_rd[CW-1:0];
                n_depth   = depth_m1;
                adj_re    = 1'b1;
                adj_raddr = r_stack_rd[SW-1:CW];
                n_state   = bptc_pkg::S_SCAN;
            end
            bptc_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_ok;
                    n_out_cnt   = r_ok ? bptc_pkg::ResultWidth'(32'(r_count) - 32'(larger))
                                       : '0;
                    n_state     = bptc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bptc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bptc_pkg::S_IDLE;
            r_vcount    <= bptc_pkg::VertCountReset;
            r_row_valid <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_valid <= n_row_valid;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                r_vcount <= pwdata[6:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_count   <= n_count;
        r_top_v   <= n_top_v;
        r_top_col <= n_top_col;
        r_red     <= n_red;
        r_blue    <= n_blue;
        r_colored <= n_colored;
        r_ok      <= n_ok;
        r_add_src <= n_add_src;
        r_add_dst <= n_add_dst;
        r_out_ok  <= n_out_ok;
        r_out_cnt <= n_out_cnt;
    end

    // Adjacency matrix: one row per vertex; a row that is not valid reads empty.
    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            r_adj_mem[adj_waddr] <= adj_wdata;
        end
        if (adj_re) begin
            r_adj_rd <= r_row_valid[adj_raddr] ? r_adj_mem[adj_raddr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (col_we) begin
            r_color_mem[col_waddr] <= col_wdata;
        end
        if (col_re) begin
            r_color_rd <= r_color_mem[col_raddr];
        end
    end

    // Walk stack below the top entry; the top entry lives in registers.
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            r_stack_rd <= r_stack_mem[stk_raddr];
        end
    end

    assign o_valid              = r_out_valid;
    assign o_two_colorable      = r_out_ok;
    assign o_smaller_side_count = r_out_cnt;

endmodule

`default_nettype wire

// ----- verif/bipartite_two_coloring_check_unit_test.sv -----
// Self-checking testbench for bipartite_two_coloring_check_unit: directed table,
// then random graph-building sequences checked against a local coloring walk.
// Depends on bptc_pkg and the unit's top level; no files or arguments are read.
`default_nettype none

module bipartite_two_coloring_check_unit_test;

    localparam logic [1:0] ModeUnused = 2'd3;
    localparam logic [bptc_pkg::CfgAddrWidth-1:0] AddrVertCount =
        {bptc_pkg::CfgIdxVertCount, 2'b00};
    localparam logic [bptc_pkg::CfgAddrWidth-1:0] AddrUnmapped  = 3'd4;
    localparam int NumVertices   = 64;
    localparam int SettleCycles  = 16;
    localparam int NumPhases     = 14;
    localparam int WordsPerPhase = 120;
    localparam int CycleLimit    = 2_000_000;

    typedef enum logic [1:0] {
        ColorNone = 2'd0,
        ColorRed  = 2'd1,
        ColorBlue = 2'd2
    } t_color;

    typedef enum logic {
        RowWord   = 1'b0,
        RowConfig = 1'b1
    } t_row_kind;

    typedef struct packed {
        logic                             colorable;
        logic [bptc_pkg::ResultWidth-1:0] side;
    } t_coloring;

    typedef struct packed {
        t_row_kind                          kind;
        logic [bptc_pkg::ModeWidth-1:0]     mode;
        logic [bptc_pkg::VertexWidth-1:0]   src;
        logic [bptc_pkg::VertexWidth-1:0]   dst;
        logic [bptc_pkg::CfgAddrWidth-1:0]  addr;
        logic [31:0]                        data;
        logic                               typed;
        logic                               colorable;
        logic [bptc_pkg::ResultWidth-1:0]   side;
    } t_plan_row;

    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n;
    logic                                   i_valid;
    logic                                   o_ready;
    logic [bptc_pkg::ModeWidth-1:0]         i_mode;
    logic [bptc_pkg::VertexWidth-1:0]       i_edge_source;
    logic [bptc_pkg::VertexWidth-1:0]       i_edge_target;
    logic                                   o_valid;
    logic                                   i_ready;
    logic                                   o_two_colorable;
    logic [bptc_pkg::ResultWidth-1:0]       o_smaller_side_count;
    logic                                   psel;
    logic                                   penable;
    logic                                   pwrite;
    logic [bptc_pkg::CfgAddrWidth-1:0]      paddr;
    logic [31:0]                            pwdata;
    logic [31:0]                            prdata;
    logic                                   pready;

    // Local copy of the matrix and the register, plus the results still owed.
    logic [NumVertices-1:0]     adj_rows [NumVertices];
    logic [6:0]                 vert_count_reg;
    t_coloring                  pending_colorings [$];
    int                         mismatches = 0;
    int                         words_sent = 0;
    int                         cycle_count = 0;
    bit                         steady_flow = 1'b0;

    // Extremes, each mode, count clamping, unmapped register and self loops.
    t_plan_row directed_plan [29] = '{
        '{RowWord,   bptc_pkg::ModeEvaluate, 6'd0,  6'd0,  3'd0, 32'd0, 1'b1, 1'b1, 7'd63},
        '{RowWord,   ModeUnused,             6'd63, 6'd63, 3'd0, 32'd0, 1'b0, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeAddEdge,  6'd0,  6'd0,  3'd0, 32'd0, 1'b0, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeEvaluate, 6'd0,  6'd0,  3'd0, 32'd0, 1'b1, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeClear,    6'd0,  6'd0,  3'd0, 32'd0, 1'b0, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeEvaluate, 6'd0,  6'd0,  3'd0, 32'd0, 1'b1, 1'b1, 7'd63},
        '{RowConfig, bptc_pkg::ModeAddEdge,  6'd0,  6'd0,  AddrVertCount, 32'd1,
          1'b0, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeAddEdge,  6'd0,  6'd1,  3'd0, 32'd0, 1'b0, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeEvaluate, 6'd0,  6'd0,  3'd0, 32'd0, 1'b1, 1'b1, 7'd0},
        '{RowConfig, bptc_pkg::ModeAddEdge,  6'd0,  6'd0,  AddrVertCount, 32'd0,
          1'b0, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeEvaluate, 6'd0,  6'd0,  3'd0, 32'd0, 1'b1, 1'b1, 7'd0},
        '{RowConfig, bptc_pkg::ModeAddEdge,  6'd0,  6'd0,  AddrVertCount, 32'hFFFF_FFFF,
          1'b0, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeAddEdge,  6'd1,  6'd63, 3'd0, 32'd0, 1'b0, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeEvaluate, 6'd0,  6'd0,  3'd0, 32'd0, 1'b1, 1'b1, 7'd62},
        '{RowWord,   bptc_pkg::ModeAddEdge,  6'd63, 6'd63, 3'd0, 32'd0, 1'b0, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeEvaluate, 6'd0,  6'd0,  3'd0, 32'd0, 1'b1, 1'b0, 7'd0},
        '{RowConfig, bptc_pkg::ModeAddEdge,  6'd0,  6'd0,  AddrUnmapped, 32'd5,
          1'b0, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeEvaluate, 6'd0,  6'd0,  3'd0, 32'd0, 1'b1, 1'b0, 7'd0},
        '{RowConfig, bptc_pkg::ModeAddEdge,  6'd0,  6'd0,  AddrVertCount, 32'd2,
          1'b0, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeClear,    6'd0,  6'd0,  3'd0, 32'd0, 1'b0, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeAddEdge,  6'd0,  6'd1,  3'd0, 32'd0, 1'b0, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeAddEdge,  6'd1,  6'd0,  3'd0, 32'd0, 1'b0, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeEvaluate, 6'd0,  6'd0,  3'd0, 32'd0, 1'b1, 1'b1, 7'd1},
        '{RowConfig, bptc_pkg::ModeAddEdge,  6'd0,  6'd0,  AddrVertCount, 32'd3,
          1'b0, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeAddEdge,  6'd1,  6'd2,  3'd0, 32'd0, 1'b0, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeAddEdge,  6'd2,  6'd0,  3'd0, 32'd0, 1'b0, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeEvaluate, 6'd0,  6'd0,  3'd0, 32'd0, 1'b1, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeAddEdge,  6'd42, 6'd21, 3'd0, 32'd0, 1'b0, 1'b0, 7'd0},
        '{RowWord,   bptc_pkg::ModeEvaluate, 6'd0,  6'd0,  3'd0, 32'd0, 1'b0, 1'b0, 7'd0}
    };

    // Register values of the first 12 random phases; 0 and 127 test clamping.
    int phase_counts [12] = '{4, 1, 64, 2, 10, 0, 16, 127, 3, 7, 12, 6};

    bipartite_two_coloring_check_unit dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_mode               (i_mode),
        .i_edge_source        (i_edge_source),
        .i_edge_target        (i_edge_target),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_two_colorable      (o_two_colorable),
        .o_smaller_side_count (o_smaller_side_count),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int effective_vertices(input logic [6:0] raw);
        if (raw < 7'd1) return 1;
        if (raw > 7'(NumVertices)) return NumVertices;
        return int'(raw);
    endfunction

    // Depth-first walk from vertex 0, scanning columns in ascending order.
    function automatic t_coloring walk_coloring();
        t_color    color [NumVertices];
        int        stack_vert [NumVertices];
        int        stack_col [NumVertices];
        int        count, depth, v, col, red, blue, k;
        t_coloring res;
        count = effective_vertices(vert_count_reg);
        for (k = 0; k < NumVertices; k++) color[k] = ColorNone;
        color[0] = ColorRed;
        stack_vert[0] = 0;
        stack_col[0] = 0;
        depth = 1;
        res.colorable = 1'b1;
        res.side = '0;
        while (depth > 0) begin
            v = stack_vert[depth-1];
            col = stack_col[depth-1];
            if (col >= count) begin
                depth--;
            end else begin
                stack_col[depth-1] = col + 1;
                if (adj_rows[v][col]) begin
                    if (color[col] == ColorNone) begin
                        color[col] = (color[v] == ColorRed) ? ColorBlue : ColorRed;
                        if (depth < NumVertices) begin
                            stack_vert[depth] = col;
                            stack_col[depth] = 0;
                            depth++;
                        end
                    end else if (color[col] == color[v]) begin
                        res.colorable = 1'b0;
                        depth = 0;
                    end
                end
            end
        end
        if (res.colorable) begin
            red = 0;
            blue = 0;
            for (k = 0; k < count; k++) begin
                if (color[k] == ColorRed) red++;
                else if (color[k] == ColorBlue) blue++;
            end
            res.side = bptc_pkg::ResultWidth'(count - ((red >= blue) ? red : blue));
        end
        return res;
    endfunction

    // Updates the local matrix; returns 1 when the word yields a result.
    function automatic bit apply_word(input logic [bptc_pkg::ModeWidth-1:0] mode,
                                      input logic [bptc_pkg::VertexWidth-1:0] src,
                                      input logic [bptc_pkg::VertexWidth-1:0] dst,
                                      output t_coloring res);
        int k;
        res = '0;
        case (mode)
            bptc_pkg::ModeAddEdge: begin
                adj_rows[src][dst] = 1'b1;
            end
            bptc_pkg::ModeClear: begin
                for (k = 0; k < NumVertices; k++) adj_rows[k] = '0;
            end
            bptc_pkg::ModeEvaluate: begin
                res = walk_coloring();
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Presents one word, waits for its handshake, then idles for a random gap.
    task automatic send_word(input logic [bptc_pkg::ModeWidth-1:0] mode,
                             input logic [bptc_pkg::VertexWidth-1:0] src,
                             input logic [bptc_pkg::VertexWidth-1:0] dst,
                             input bit typed = 1'b0,
                             input t_coloring typed_want = '0);
        t_coloring predicted;
        int gap;
        i_valid <= 1'b1;
        i_mode <= mode;
        i_edge_source <= src;
        i_edge_target <= dst;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        if (apply_word(mode, src, dst, predicted))
            pending_colorings.push_back(typed ? typed_want : predicted);
        words_sent++;
        gap = steady_flow ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // An add or clear word may still be in flight after the last result.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_colorings.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [bptc_pkg::CfgAddrWidth-1:0] addr,
                                  input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == AddrVertCount) vert_count_reg = data[6:0];
    endtask

    // Builds a mostly two-colorable graph reachable from vertex 0, with an
    // occasional same-side edge, stray words and mid-sequence clears.
    task automatic run_coloring_sequence(input int eff);
        logic [NumVertices-1:0] side_of;
        int reached [NumVertices];
        int reached_n, n_edges, bad_at, k, s, t, tries, pick;
        side_of = {$urandom, $urandom};
        side_of[0] = 1'b0;
        reached[0] = 0;
        reached_n = 1;
        n_edges = $urandom_range(1, (eff < 12) ? 2 * eff + 2 : 24);
        bad_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n_edges - 1) : -1;
        if ($urandom_range(0, 3) != 0)
            send_word(bptc_pkg::ModeClear, 6'($urandom), 6'($urandom));
        for (k = 0; k < n_edges; k++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                send_word(ModeUnused, 6'($urandom), 6'($urandom));
            end else if (pick == 1) begin
                send_word(bptc_pkg::ModeAddEdge, 6'($urandom), 6'($urandom));
            end else if (pick == 2) begin
                send_word(bptc_pkg::ModeClear, 6'($urandom), 6'($urandom));
            end else begin
                s = reached[$urandom_range(0, reached_n - 1)];
                t = $urandom_range(0, eff - 1);
                for (tries = 0;
                     tries < 8 && ((side_of[t] == side_of[s]) != (k == bad_at));
                     tries++)
                    t = $urandom_range(0, eff - 1);
                send_word(bptc_pkg::ModeAddEdge, 6'(s), 6'(t));
                if (reached_n < NumVertices) begin
                    reached[reached_n] = t;
                    reached_n++;
                end
            end
        end
        send_word(bptc_pkg::ModeEvaluate, 6'($urandom), 6'($urandom));
    endtask

    // Result side: random stalls, each accepted word checked against the oldest.
    initial begin : result_check
        int stall;
        t_coloring want;
        i_ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
            if (pending_colorings.size() == 0) begin
                report_mismatch($sformatf("result word with none pending: colorable %0b side %0d",
                                          o_two_colorable, o_smaller_side_count));
            end else begin
                want = pending_colorings.pop_front();
                if (o_two_colorable !== want.colorable)
                    report_mismatch($sformatf("two_colorable got %0b expected %0b",
                                              o_two_colorable, want.colorable));
                if (o_smaller_side_count !== want.side)
                    report_mismatch($sformatf("smaller_side_count got %0d expected %0d",
                                              o_smaller_side_count, want.side));
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int row, phase, raw, eff, start;
        t_plan_row r;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_mode <= bptc_pkg::ModeAddEdge;
        i_edge_source <= '0;
        i_edge_target <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        for (row = 0; row < NumVertices; row++) adj_rows[row] = '0;
        vert_count_reg = bptc_pkg::VertCountReset;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < $size(directed_plan); row++) begin
            r = directed_plan[row];
            if (r.kind == RowConfig) begin
                drain_results();
                write_register(r.addr, r.data);
            end else begin
                send_word(r.mode, r.src, r.dst, r.typed, '{r.colorable, r.side});
            end
        end

        for (phase = 0; phase < NumPhases; phase++) begin
            drain_results();
            steady_flow = (phase % 4 == 2);
            raw = (phase < $size(phase_counts)) ? phase_counts[phase] : $urandom_range(1, 20);
            write_register(AddrVertCount, ($urandom & 32'hFFFF_FF80) | 32'(raw));
            eff = effective_vertices(7'(raw));
            start = words_sent;
            while (words_sent - start < WordsPerPhase) run_coloring_sequence(eff);
        end
        steady_flow = 1'b0;

        drain_results();
        if (mismatches == 0 && pending_colorings.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
src/bptc_pkg.sv
src/bipartite_two_coloring_check_unit.sv
verif/bipartite_two_coloring_check_unit_test.sv
